FILE: hw/rtl/bpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpm_pkg: shared types and constants for the BMP pixel to mono converter
// Sizes, register codes, pipeline structs and the pixel classification rules.
// ----------------------------------------------------------------------------
package bpm_pkg;

   localparam int MAX_WIDTH       = 4096;
   localparam int MAX_ROWS        = 4096;
   localparam int PALETTE_ENTRIES = 256;

   // raw width of the dimension registers
   localparam int REG_W     = 13;
   localparam int DIM_LIMIT = (MAX_WIDTH > MAX_ROWS) ? MAX_WIDTH : MAX_ROWS;
   localparam int DIM_W     = ($clog2(DIM_LIMIT + 1) > REG_W) ? $clog2(DIM_LIMIT + 1) : REG_W;
   localparam int RB_W      = $clog2(MAX_WIDTH * 3 + 4);
   localparam int PROD_W    = $clog2(MAX_WIDTH * 24 + 8);
   localparam int PAL_AW    = $clog2(PALETTE_ENTRIES);
   localparam int COL_W     = 12;
   localparam int ROW_W     = 12;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;

   localparam logic [7:0] WHITE_LEVEL = 8'h80;
   localparam logic [7:0] COLOR_LEVEL = 8'hF0;
   localparam logic [9:0] SUM_LEVEL   = 10'd384;

   // palette memory word layout
   localparam int PAL_WHITE_BIT = 1;
   localparam int PAL_COLOR_BIT = 0;

   localparam logic [2:0]       RST_DEPTH_CODE   = 3'd4;
   localparam logic [REG_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
   localparam logic [REG_W-1:0] RST_SHOWN_WIDTH  = 13'd640;
   localparam logic [REG_W-1:0] RST_SHOWN_ROWS   = 13'd480;
   localparam logic             RST_BOTTOM_UP    = 1'b1;

   typedef enum logic {
      CMD_PALETTE = 1'b0,
      CMD_DATA    = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      DEPTH_1  = 3'd0,
      DEPTH_4  = 3'd1,
      DEPTH_8  = 3'd2,
      DEPTH_16 = 3'd3,
      DEPTH_24 = 3'd4
   } depth_type;

   typedef enum logic [2:0] {
      REG_DEPTH_CODE   = 3'd0,
      REG_RGB565       = 3'd1,
      REG_STRICT_WHITE = 3'd2,
      REG_IMAGE_WIDTH  = 3'd3,
      REG_SHOWN_WIDTH  = 3'd4,
      REG_SHOWN_ROWS   = 3'd5,
      REG_BOTTOM_UP    = 3'd6
   } reg_index_type;

   typedef struct packed {
      depth_type         depth;
      logic              rgb565;
      logic              strict;
      logic [DIM_W-1:0]  img_w;
      logic [DIM_W-1:0]  shw_w;
      logic [DIM_W-1:0]  shw_r;
      logic              bottom_up;
      logic [RB_W-1:0]   row_bytes;
   } cfg_type;

   typedef struct packed {
      logic              indexed;
      logic              in_range;
      logic              white;
      logic              colored;
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  row;
      logic              last;
      logic              frame_done;
   } pix_type;

   typedef struct packed {
      logic              en;
      logic [PAL_AW-1:0] addr;
      logic              white;
      logic              colored;
   } pal_wr_type;

   function automatic logic whitish(input logic strict, input logic [7:0] r,
                                    input logic [7:0] g, input logic [7:0] b);
      logic [9:0] sum;
      sum = 10'(r) + 10'(g) + 10'(b);
      if (strict) begin
         return (r > WHITE_LEVEL) && (g > WHITE_LEVEL) && (b > WHITE_LEVEL);
      end
      return sum > SUM_LEVEL;
   endfunction

   function automatic logic colored(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b);
      return (r > COLOR_LEVEL) || ((g > COLOR_LEVEL) && (b > COLOR_LEVEL));
   endfunction

   function automatic logic is_indexed(input depth_type depth);
      return (depth == DEPTH_1) || (depth == DEPTH_4) || (depth == DEPTH_8);
   endfunction

endpackage

FILE: hw/rtl/bmp_pixel_to_mono_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_pixel_to_mono_converter_top: BMP pixel bytes to white/colored flags
// Unpacks BMP pixel-array bytes and classifies each shown pixel for a
// two-tone plus color panel.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per accepted cycle: a palette load (cmd 0) or one
//   raw pixel-array byte (cmd 1). rsp_* carries one pixel per word, tagged
//   with its column, display row, last-of-byte and end-of-frame marks.
//   Configure over the APB port while no byte is in flight.
//   The first pixel of a byte passes the item register, then the output
//   register. Throughput: one output pixel per cycle while rsp_stall is low,
//   set by the single palette read port. A palette load yields no pixel, a
//   byte at 8, 16 or 24 bits at most one, and a byte at 1 or 4 bits one
//   per shown pixel it holds (up to 8 or 2).
//   Reset restores the default registers and clears the row, column and byte
//   position; palette contents are undefined until loaded.
//   When rsp_stall is high a valid output word holds and the sequencer
//   stops at its next pixel; req_stall rises until the byte in hand is done.
// ----------------------------------------------------------------------------
module bmp_pixel_to_mono_converter_top import bpm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_cmd,
   input  logic [7:0]        req_palette_index,
   input  logic [7:0]        req_red,
   input  logic [7:0]        req_green,
   input  logic [7:0]        req_blue,
   input  logic [7:0]        req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_is_white,
   output logic              rsp_is_colored,
   output logic [COL_W-1:0]  rsp_column,
   output logic [ROW_W-1:0]  rsp_display_row,
   output logic              rsp_last_of_item,
   output logic              rsp_frame_done
);

   cfg_type           cfg;
   logic              pix_valid;
   logic              pix_ready;
   pix_type           pix;
   logic [PAL_AW-1:0] rd_addr;
   pal_wr_type        pal_wr;

   bpm_cfg u_cfg (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bpm_unpack u_unpack (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_palette_index (req_palette_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_data_byte     (req_data_byte),
      .pix_valid         (pix_valid),
      .pix_ready         (pix_ready),
      .pix               (pix),
      .rd_addr           (rd_addr),
      .pal_wr            (pal_wr)
   );

   bpm_palette u_palette (
      .clock            (clock),
      .reset            (reset),
      .pix_valid        (pix_valid),
      .pix_ready        (pix_ready),
      .pix              (pix),
      .rd_addr          (rd_addr),
      .pal_wr           (pal_wr),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_is_white     (rsp_is_white),
      .rsp_is_colored   (rsp_is_colored),
      .rsp_column       (rsp_column),
      .rsp_display_row  (rsp_display_row),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_frame_done   (rsp_frame_done)
   );

endmodule

FILE: hw/rtl/bpm_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpm_cfg: configuration registers
// APB register file plus the clamped widths, depth decode and padded row size.
// ----------------------------------------------------------------------------
module bpm_cfg import bpm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic [2:0]       depth_code_ff, depth_code_in;
   logic             rgb565_ff, rgb565_in;
   logic             strict_ff, strict_in;
   logic [REG_W-1:0] img_raw_ff, img_raw_in;
   logic [REG_W-1:0] shw_raw_ff, shw_raw_in;
   logic [REG_W-1:0] rows_raw_ff, rows_raw_in;
   logic             bottom_up_ff, bottom_up_in;

   logic             wr_en;
   reg_index_type    reg_index;
   logic [DIM_W-1:0] img_ext;
   logic [DIM_W-1:0] shw_ext;
   logic [DIM_W-1:0] rows_ext;
   logic [DIM_W-1:0] img_w;
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] bytes;
   logic [PROD_W-1:0] padded;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite && pready;
   assign reg_index = reg_index_type'(paddr[4:2]);

   always_comb begin
      depth_code_in = depth_code_ff;
      rgb565_in     = rgb565_ff;
      strict_in     = strict_ff;
      img_raw_in    = img_raw_ff;
      shw_raw_in    = shw_raw_ff;
      rows_raw_in   = rows_raw_ff;
      bottom_up_in  = bottom_up_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_DEPTH_CODE:   depth_code_in = pwdata[2:0];
            REG_RGB565:       rgb565_in     = pwdata[0];
            REG_STRICT_WHITE: strict_in     = pwdata[0];
            REG_IMAGE_WIDTH:  img_raw_in    = pwdata[REG_W-1:0];
            REG_SHOWN_WIDTH:  shw_raw_in    = pwdata[REG_W-1:0];
            REG_SHOWN_ROWS:   rows_raw_in   = pwdata[REG_W-1:0];
            REG_BOTTOM_UP:    bottom_up_in  = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_code_ff <= RST_DEPTH_CODE;
         rgb565_ff     <= 1'b0;
         strict_ff     <= 1'b0;
         img_raw_ff    <= RST_IMAGE_WIDTH;
         shw_raw_ff    <= RST_SHOWN_WIDTH;
         rows_raw_ff   <= RST_SHOWN_ROWS;
         bottom_up_ff  <= RST_BOTTOM_UP;
      end else begin
         depth_code_ff <= depth_code_in;
         rgb565_ff     <= rgb565_in;
         strict_ff     <= strict_in;
         img_raw_ff    <= img_raw_in;
         shw_raw_ff    <= shw_raw_in;
         rows_raw_ff   <= rows_raw_in;
         bottom_up_ff  <= bottom_up_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_DEPTH_CODE:   prdata = CSR_DW'(depth_code_ff);
         REG_RGB565:       prdata = CSR_DW'(rgb565_ff);
         REG_STRICT_WHITE: prdata = CSR_DW'(strict_ff);
         REG_IMAGE_WIDTH:  prdata = CSR_DW'(img_raw_ff);
         REG_SHOWN_WIDTH:  prdata = CSR_DW'(shw_raw_ff);
         REG_SHOWN_ROWS:   prdata = CSR_DW'(rows_raw_ff);
         REG_BOTTOM_UP:    prdata = CSR_DW'(bottom_up_ff);
         default:          prdata = '0;
      endcase
   end

   // clamp dimensions: image width and shown rows to 1..max, shown width to 1..image width
   always_comb begin
      img_ext  = DIM_W'(img_raw_ff);
      shw_ext  = DIM_W'(shw_raw_ff);
      rows_ext = DIM_W'(rows_raw_ff);

      if (img_ext == '0) begin
         img_w = DIM_W'(1);
      end else if (img_ext > DIM_W'(MAX_WIDTH)) begin
         img_w = DIM_W'(MAX_WIDTH);
      end else begin
         img_w = img_ext;
      end

      cfg.img_w = img_w;
      if (shw_ext == '0) begin
         cfg.shw_w = DIM_W'(1);
      end else if (shw_ext > img_w) begin
         cfg.shw_w = img_w;
      end else begin
         cfg.shw_w = shw_ext;
      end

      if (rows_ext == '0) begin
         cfg.shw_r = DIM_W'(1);
      end else if (rows_ext > DIM_W'(MAX_ROWS)) begin
         cfg.shw_r = DIM_W'(MAX_ROWS);
      end else begin
         cfg.shw_r = rows_ext;
      end

      unique case (depth_code_ff)
         3'd0:    cfg.depth = DEPTH_1;
         3'd1:    cfg.depth = DEPTH_4;
         3'd2:    cfg.depth = DEPTH_8;
         3'd3:    cfg.depth = DEPTH_16;
         default: cfg.depth = DEPTH_24;
      endcase

      cfg.rgb565    = rgb565_ff;
      cfg.strict    = strict_ff;
      cfg.bottom_up = bottom_up_ff;

      unique case (cfg.depth)
         DEPTH_1:  prod = PROD_W'(img_w);
         DEPTH_4:  prod = PROD_W'(img_w) << 2;
         DEPTH_8:  prod = PROD_W'(img_w) << 3;
         DEPTH_16: prod = PROD_W'(img_w) << 4;
         default:  prod = (PROD_W'(img_w) << 4) + (PROD_W'(img_w) << 3);
      endcase
      // round bits up to bytes, then bytes up to a multiple of four
      bytes  = (prod + PROD_W'(7)) >> 3;
      padded = (bytes + PROD_W'(3)) & ~PROD_W'(3);
      cfg.row_bytes = padded[RB_W-1:0];
   end

endmodule

FILE: hw/rtl/bpm_unpack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpm_unpack: item register and pixel sequencer
// Holds one word, steps through its pixels one per cycle unless stalled,
// tracks the row position and issues palette reads and palette writes.
// ----------------------------------------------------------------------------
module bpm_unpack import bpm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_cmd,
   input  logic [7:0]        req_palette_index,
   input  logic [7:0]        req_red,
   input  logic [7:0]        req_green,
   input  logic [7:0]        req_blue,
   input  logic [7:0]        req_data_byte,
   output logic              pix_valid,
   input  logic              pix_ready,
   output pix_type           pix,
   output logic [PAL_AW-1:0] rd_addr,
   output pal_wr_type        pal_wr
);

   logic             item_valid_ff, item_valid_in;
   cmd_type          item_cmd_ff, item_cmd_in;
   logic [7:0]       item_index_ff, item_index_in;
   logic [7:0]       item_red_ff, item_red_in;
   logic [7:0]       item_green_ff, item_green_in;
   logic [7:0]       item_blue_ff, item_blue_in;
   logic [7:0]       item_byte_ff, item_byte_in;
   logic [2:0]       sub_ff, sub_in;
   logic [DIM_W-1:0] col_ff, col_in;
   logic [RB_W-1:0]  rbc_ff, rbc_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic [1:0]       phase_ff, phase_in;
   logic [15:0]      held_ff, held_in;

   logic             is_data;
   logic             indexed;
   logic [2:0]       per_last;
   logic [1:0]       phase_need;
   logic             need_met;
   logic             col_in_img;
   logic [DIM_W-1:0] col_sub;
   logic [DIM_W-1:0] pix_col;
   logic             emit;
   logic             last_step;
   logic             step;
   logic             item_done;
   logic             accept;
   logic [7:0]       pix_index;
   logic [7:0]       red, green, blue;
   logic [7:0]       lsb, msb;
   logic [DIM_W:0]   col_plus;
   logic [RB_W-1:0]  rbc_plus;
   logic [DIM_W:0]   row_plus;
   logic [DIM_W-1:0] row_cap;
   logic [DIM_W-1:0] disp_row;

   assign is_data    = (item_cmd_ff == CMD_DATA);
   assign indexed    = is_indexed(cfg.depth);
   assign col_in_img = (col_ff < cfg.img_w);
   assign col_sub    = col_ff + DIM_W'(sub_ff);
   assign need_met   = (phase_ff >= phase_need);

   always_comb begin
      unique case (cfg.depth)
         DEPTH_1: per_last = 3'd7;
         DEPTH_4: per_last = 3'd1;
         default: per_last = 3'd0;
      endcase
      phase_need = (cfg.depth == DEPTH_16) ? 2'd1 : 2'd2;
   end

   // step, emit and end-of-word decisions
   always_comb begin
      if (indexed) begin
         emit      = is_data && (col_ff < cfg.shw_w);
         last_step = !emit || (sub_ff == per_last)
                     || ((col_sub + DIM_W'(1)) == cfg.shw_w);
         pix_col   = col_sub;
      end else begin
         emit      = is_data && col_in_img && need_met && (col_ff < cfg.shw_w);
         last_step = 1'b1;
         pix_col   = col_ff;
      end
      if (!is_data) begin
         last_step = 1'b1;
      end
   end

   assign step      = item_valid_ff && (!emit || pix_ready);
   assign item_done = step && last_step;
   assign req_stall = item_valid_ff && !item_done;
   assign accept    = req_valid && !req_stall;

   // palette index of the current sub-pixel, most significant first
   always_comb begin
      unique case (cfg.depth)
         DEPTH_1: pix_index = {7'b0, item_byte_ff[3'd7 - sub_ff]};
         DEPTH_4: pix_index = sub_ff[0] ? {4'b0, item_byte_ff[3:0]}
                                        : {4'b0, item_byte_ff[7:4]};
         default: pix_index = item_byte_ff;
      endcase
   end

   // direct color pixels: 16 bit little-endian or 24 bit BGR
   always_comb begin
      lsb = held_ff[7:0];
      msb = item_byte_ff;
      if (cfg.depth == DEPTH_16) begin
         blue = {lsb[4:0], 3'b000};
         if (cfg.rgb565) begin
            green = {msb[2:0], lsb[7:5], 2'b00};
            red   = {msb[7:3], 3'b000};
         end else begin
            green = {msb[1:0], lsb[7:5], 3'b000};
            red   = {msb[6:2], 3'b000};
         end
      end else begin
         blue  = held_ff[7:0];
         green = held_ff[15:8];
         red   = msb;
      end
   end

   always_comb begin
      row_cap  = (row_ff < cfg.shw_r) ? row_ff : (cfg.shw_r - DIM_W'(1));
      disp_row = cfg.bottom_up ? (cfg.shw_r - DIM_W'(1) - row_cap) : row_ff;

      pix.indexed    = indexed;
      pix.in_range   = ({1'b0, pix_index} < 9'(PALETTE_ENTRIES));
      pix.white      = whitish(cfg.strict, red, green, blue);
      pix.colored    = colored(red, green, blue);
      pix.column     = pix_col[COL_W-1:0];
      pix.row        = disp_row[ROW_W-1:0];
      pix.last       = last_step;
      pix.frame_done = ((row_ff + DIM_W'(1)) == cfg.shw_r)
                       && ((pix_col + DIM_W'(1)) == cfg.shw_w);
   end

   assign pix_valid = item_valid_ff && emit;
   assign rd_addr   = pix_index[PAL_AW-1:0];

   always_comb begin
      pal_wr.en      = item_valid_ff && !is_data
                       && ({1'b0, item_index_ff} < 9'(PALETTE_ENTRIES));
      pal_wr.addr    = item_index_ff[PAL_AW-1:0];
      pal_wr.white   = whitish(cfg.strict, item_red_ff, item_green_ff, item_blue_ff);
      pal_wr.colored = colored(item_red_ff, item_green_ff, item_blue_ff);
   end

   assign col_plus = (DIM_W + 1)'(col_ff) + (DIM_W + 1)'(per_last) + (DIM_W + 1)'(1);
   assign rbc_plus = rbc_ff + RB_W'(1);
   assign row_plus = (DIM_W + 1)'(row_ff) + (DIM_W + 1)'(1);

   always_comb begin
      item_valid_in = item_valid_ff;
      item_cmd_in   = item_cmd_ff;
      item_index_in = item_index_ff;
      item_red_in   = item_red_ff;
      item_green_in = item_green_ff;
      item_blue_in  = item_blue_ff;
      item_byte_in  = item_byte_ff;
      sub_in        = sub_ff;
      col_in        = col_ff;
      rbc_in        = rbc_ff;
      row_in        = row_ff;
      phase_in      = phase_ff;
      held_in       = held_ff;

      if (step) begin
         sub_in = item_done ? 3'd0 : (sub_ff + 3'd1);
      end

      if (item_done && is_data) begin
         if (indexed) begin
            if (col_in_img) begin
               col_in = (col_plus > (DIM_W + 1)'(cfg.img_w)) ? cfg.img_w
                                                              : col_plus[DIM_W-1:0];
            end
         end else if (col_in_img) begin
            if (need_met) begin
               col_in   = col_ff + DIM_W'(1);
               phase_in = 2'd0;
               held_in  = 16'd0;
            end else begin
               held_in  = held_ff | (phase_ff[0] ? {item_byte_ff, 8'd0}
                                                 : {8'd0, item_byte_ff});
               phase_in = phase_ff + 2'd1;
            end
         end

         // end of padded row: drop the rest and advance the row
         if (rbc_plus >= cfg.row_bytes) begin
            rbc_in   = '0;
            col_in   = '0;
            phase_in = 2'd0;
            held_in  = 16'd0;
            row_in   = (row_plus >= (DIM_W + 1)'(cfg.shw_r)) ? '0 : row_plus[DIM_W-1:0];
         end else begin
            rbc_in   = rbc_plus;
         end
      end

      if (accept) begin
         item_valid_in = 1'b1;
         item_cmd_in   = cmd_type'(req_cmd);
         item_index_in = req_palette_index;
         item_red_in   = req_red;
         item_green_in = req_green;
         item_blue_in  = req_blue;
         item_byte_in  = req_data_byte;
      end else if (item_done) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         sub_ff        <= 3'd0;
         col_ff        <= '0;
         rbc_ff        <= '0;
         row_ff        <= '0;
         phase_ff      <= 2'd0;
         held_ff       <= 16'd0;
      end else begin
         item_valid_ff <= item_valid_in;
         sub_ff        <= sub_in;
         col_ff        <= col_in;
         rbc_ff        <= rbc_in;
         row_ff        <= row_in;
         phase_ff      <= phase_in;
         held_ff       <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      item_cmd_ff   <= item_cmd_in;
      item_index_ff <= item_index_in;
      item_red_ff   <= item_red_in;
      item_green_ff <= item_green_in;
      item_blue_ff  <= item_blue_in;
      item_byte_ff  <= item_byte_in;
   end

   a_col_bounded: assert property (@(posedge clock) disable iff (reset)
      col_ff <= DIM_W'(MAX_WIDTH))
      else $error("column counter beyond maximum width");

   a_item_held: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !item_done |=> item_valid_ff && $stable(item_byte_ff))
      else $error("word dropped before its pixels were sequenced");

   a_sub_owned: assert property (@(posedge clock) disable iff (reset)
      sub_ff != 3'd0 |-> item_valid_ff)
      else $error("sub-pixel count left over without a word");

endmodule

FILE: hw/rtl/bpm_palette.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpm_palette: palette flag memory and output register
// Two flags per entry in a synchronous RAM; the read lands together with the
// pixel in the output register.
// ----------------------------------------------------------------------------
module bpm_palette import bpm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              pix_valid,
   output logic              pix_ready,
   input  pix_type           pix,
   input  logic [PAL_AW-1:0] rd_addr,
   input  pal_wr_type        pal_wr,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_is_white,
   output logic              rsp_is_colored,
   output logic [COL_W-1:0]  rsp_column,
   output logic [ROW_W-1:0]  rsp_display_row,
   output logic              rsp_last_of_item,
   output logic              rsp_frame_done
);

   logic [1:0] pal_mem [PALETTE_ENTRIES];
   logic [1:0] rd_data_ff;
   logic       out_valid_ff, out_valid_in;
   pix_type    out_pix_ff;
   logic       load;
   logic       rd_en;

   assign pix_ready = !out_valid_ff || !rsp_stall;
   assign load      = pix_valid && pix_ready;
   assign rd_en     = load && pix.indexed;

   always_ff @(posedge clock) begin
      if (pal_wr.en) begin
         pal_mem[pal_wr.addr] <= {pal_wr.white, pal_wr.colored};
      end
      if (rd_en) begin
         rd_data_ff <= pal_mem[rd_addr];
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_pix_ff <= pix;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_is_white     = out_pix_ff.indexed
                             ? (out_pix_ff.in_range && rd_data_ff[PAL_WHITE_BIT])
                             : out_pix_ff.white;
   assign rsp_is_colored   = out_pix_ff.indexed
                             ? (out_pix_ff.in_range && rd_data_ff[PAL_COLOR_BIT])
                             : out_pix_ff.colored;
   assign rsp_column       = out_pix_ff.column;
   assign rsp_display_row  = out_pix_ff.row;
   assign rsp_last_of_item = out_pix_ff.last;
   assign rsp_frame_done   = out_pix_ff.frame_done;

   a_frame_ends_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_last_of_item)
      else $error("frame end pixel not marked last of its word");

   a_read_with_pixel: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> out_valid_ff && out_pix_ff.indexed)
      else $error("palette read without an indexed pixel behind it");

endmodule
